// ===== rtl/bda_pkg.sv =====
// Shared types and constants for the button debounce and auto-repeat unit.
package bda_pkg;

  // Register reset values
  localparam logic [15:0] DebounceMsReset = 16'd50;

  // Output event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_REPEAT  = 2'd3
  } event_kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEBOUNCE_MS     = 3'd0,
    CFG_FIRST_REPEAT_MS = 3'd1,
    CFG_MIN_REPEAT_MS   = 3'd2,
    CFG_ACT_ON_PRESS    = 3'd3,
    CFG_ACT_ON_RELEASE  = 3'd4,
    CFG_TOGGLE_MODE     = 3'd5
  } cfg_idx_e;

  // Configuration register file
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] first_repeat_ms;
    logic [15:0] min_repeat_ms;
    logic        act_on_press;
    logic        act_on_release;
    logic        toggle_mode;
  } bda_cfg_t;

  // Per-button tracking state
  typedef struct packed {
    logic        candidate_level;
    logic [31:0] debounce_start;
    logic        accepted_level;
    logic [15:0] repeats_done;
    logic [31:0] last_change_time;
    logic [31:0] held_duration;
    logic [15:0] current_interval;
    logic [31:0] next_repeat_time;
    logic        output_bit;
  } bda_state_t;

  // One poll sample
  typedef struct packed {
    logic        raw_pressed;
    logic [31:0] now_ms;
  } bda_poll_t;

  // One result item
  typedef struct packed {
    logic        pressed_out;
    event_kind_e event_kind;
    logic        activate;
    logic [15:0] repeat_count;
    logic [31:0] last_duration_ms;
    logic        bound_value;
  } bda_result_t;

endpackage

// ===== rtl/bda_step.sv =====
// Next-state and result logic for one poll: debounce, acceptance and repeat.
module bda_step (
  input  bda_pkg::bda_cfg_t    cfg_i,
  input  bda_pkg::bda_state_t  state_i,
  input  bda_pkg::bda_poll_t   poll_i,
  output bda_pkg::bda_state_t  state_o,
  output bda_pkg::bda_result_t result_o
);
  import bda_pkg::*;

  logic [31:0] start_n;
  logic [31:0] deb_limit;
  logic        accept;
  logic        rep_fire;
  logic [15:0] ci_sub;
  logic [15:0] ci_rep;
  bda_state_t  st_acc;
  logic        act_acc;
  event_kind_e ev_acc;

  // Restart the debounce timer on any change of the raw level
  assign start_n   = (poll_i.raw_pressed != state_i.candidate_level) ?
                     poll_i.now_ms : state_i.debounce_start;
  assign deb_limit = start_n + {16'd0, cfg_i.debounce_ms};
  assign accept    = (poll_i.now_ms > deb_limit) &&
                     (poll_i.raw_pressed != state_i.accepted_level);

  // Acceptance of a new debounced level
  always_comb begin
    st_acc                 = state_i;
    st_acc.candidate_level = poll_i.raw_pressed;
    st_acc.debounce_start  = start_n;
    act_acc                = 1'b0;
    ev_acc                 = EV_NONE;
    if (accept) begin
      st_acc.accepted_level = poll_i.raw_pressed;
      if (poll_i.raw_pressed) begin
        st_acc.repeats_done = '0;
      end
      if (cfg_i.toggle_mode) begin
        if (poll_i.raw_pressed) begin
          st_acc.output_bit = ~state_i.output_bit;
        end
      end else begin
        st_acc.output_bit = poll_i.raw_pressed;
      end
      if (state_i.last_change_time != '0) begin
        st_acc.held_duration = poll_i.now_ms - state_i.last_change_time;
      end
      st_acc.last_change_time = poll_i.now_ms;
      if (poll_i.raw_pressed && (cfg_i.first_repeat_ms != '0)) begin
        st_acc.current_interval = cfg_i.first_repeat_ms;
        st_acc.next_repeat_time = poll_i.now_ms + {16'd0, cfg_i.first_repeat_ms};
      end else begin
        st_acc.next_repeat_time = '0;
      end
      act_acc = poll_i.raw_pressed ? cfg_i.act_on_press : cfg_i.act_on_release;
      ev_acc  = poll_i.raw_pressed ? EV_PRESS : EV_RELEASE;
    end
  end

  // Auto-repeat: shrink the interval, clamped at the minimum
  assign rep_fire = (st_acc.next_repeat_time != '0) &&
                    (poll_i.now_ms > st_acc.next_repeat_time);
  assign ci_sub   = st_acc.current_interval - cfg_i.min_repeat_ms;
  always_comb begin
    ci_rep = st_acc.current_interval;
    if (st_acc.current_interval > cfg_i.min_repeat_ms) begin
      ci_rep = (ci_sub < cfg_i.min_repeat_ms) ? cfg_i.min_repeat_ms : ci_sub;
    end
  end

  always_comb begin
    state_o             = st_acc;
    result_o.activate   = act_acc;
    result_o.event_kind = ev_acc;
    if (rep_fire) begin
      state_o.current_interval = ci_rep;
      state_o.next_repeat_time = poll_i.now_ms + {16'd0, ci_rep};
      if (st_acc.repeats_done != 16'hFFFF) begin
        state_o.repeats_done = st_acc.repeats_done + 16'd1;
      end
      result_o.activate = 1'b1;
      if (ev_acc == EV_NONE) begin
        result_o.event_kind = EV_REPEAT;
      end
    end
    result_o.pressed_out      = state_o.accepted_level;
    result_o.repeat_count     = state_o.repeats_done;
    result_o.last_duration_ms = state_o.held_duration;
    result_o.bound_value      = state_o.output_bit;
  end

endmodule

// ===== rtl/button_debounce_autorepeat_unit.sv =====
// Top level of the button debounce and auto-repeat unit: registers and handshakes.
//
// Each poll transaction (raw level plus millisecond time) yields exactly one
// result transaction with the debounced level, an event code (none, press,
// release, repeat), the activation flag, the repeat count, the duration of the
// previous state and the follow/toggle bit. A poll is captured in an input
// register and worked out into an output register once that register is free or
// being drained, so one poll is taken every cycle; the only limit
// is back-pressure on the result side. Configuration writes are always taken
// and apply to polls processed after the write.
module button_debounce_autorepeat_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Poll input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [0] raw_pressed, [32:1] now_ms, rest zero
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // [0] pressed_out, [1] activate,
                                     // [17:2] repeat_count, [49:18] last_duration_ms,
                                     // [50] bound_value, rest zero
  output logic [1:0]  m_axis_tuser   // [1:0] event_kind
);
  import bda_pkg::*;

  bda_cfg_t    cfg_q;
  bda_state_t  state_q, state_d;
  bda_poll_t   poll_q;
  bda_result_t res_q, res_d;
  logic        in_valid_q;
  logic        out_valid_q;
  logic        advance;
  logic        in_take;
  logic        cfg_take;

  // Handshake control
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_take      = cfg_valid_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DebounceMsReset;
      cfg_q.first_repeat_ms <= '0;
      cfg_q.min_repeat_ms   <= '0;
      cfg_q.act_on_press    <= 1'b1;
      cfg_q.act_on_release  <= 1'b0;
      cfg_q.toggle_mode     <= 1'b0;
    end else if (cfg_take) begin
      case (cfg_index_i)
        CFG_DEBOUNCE_MS:     cfg_q.debounce_ms     <= cfg_data_i;
        CFG_FIRST_REPEAT_MS: cfg_q.first_repeat_ms <= cfg_data_i;
        CFG_MIN_REPEAT_MS:   cfg_q.min_repeat_ms   <= cfg_data_i;
        CFG_ACT_ON_PRESS:    cfg_q.act_on_press    <= cfg_data_i[0];
        CFG_ACT_ON_RELEASE:  cfg_q.act_on_release  <= cfg_data_i[0];
        CFG_TOGGLE_MODE:     cfg_q.toggle_mode     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      poll_q.raw_pressed <= s_axis_tdata[0];
      poll_q.now_ms      <= s_axis_tdata[32:1];
    end
  end

  // Per-poll update
  bda_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .poll_i   (poll_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Tracking state, updated once per processed poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.event_kind;
  assign m_axis_tdata  = {5'd0, res_q.bound_value, res_q.last_duration_ms,
                          res_q.repeat_count, res_q.activate, res_q.pressed_out};

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while a stage is free");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed poll did not produce a result");

  a_press_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.event_kind == EV_PRESS)) |->
      (res_q.pressed_out && (res_q.repeat_count == '0 || res_q.repeat_count == 16'd1)))
    else $error("press result with wrong level or repeat count");

  a_release_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.event_kind == EV_RELEASE)) |-> !res_q.pressed_out)
    else $error("release result reports pressed");

  a_repeat_activates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.event_kind == EV_REPEAT)) |-> res_q.activate)
    else $error("repeat result without activation");

endmodule
